// ----- rtl/midi_step_sequencer_assert.svh -----
// Assertion macros for the step sequencer RTL
`ifndef MIDI_STEP_SEQUENCER_ASSERT_SVH
`define MIDI_STEP_SEQUENCER_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define MSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mss_pkg.sv -----
// Types and constants shared by the step sequencer modules
package mss_pkg;

  // Input beat: clock tick or received MIDI byte
  typedef enum logic {
    OP_TICK      = 1'b0,
    OP_MIDI_BYTE = 1'b1
  } op_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] midi_byte;
  } in_beat_t;

  // Output beat
  typedef enum logic [1:0] {
    EV_NOTE_OFF    = 2'd0,
    EV_NOTE_ON     = 2'd1,
    EV_STEP_STORED = 2'd2
  } ev_kind_e;

  localparam int unsigned STEP_IDX_W = 3;

  typedef struct packed {
    ev_kind_e                event_kind;
    logic [3:0]              event_channel;
    logic [7:0]              note_number;
    logic [7:0]              velocity;
    logic [STEP_IDX_W-1:0]   step_index;
    logic                    last_of_run;
  } out_beat_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMPO        = 2'd0,
    CFG_PLAY_MODE    = 2'd1,
    CFG_TRANSPOSE    = 2'd2,
    CFG_MIDI_CHANNEL = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 9;

  // Play modes (bit 0 set means stopped, other even values are random)
  localparam logic [2:0] PLAY_FORWARD  = 3'd2;
  localparam logic [2:0] PLAY_BACKWARD = 3'd4;
  localparam logic [2:0] PLAY_MODE_RST = 3'd1;

  // Commands passed from the front end to the back end
  typedef enum logic {
    CMD_FIRE  = 1'b0,
    CMD_STORE = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] key;
    logic [7:0] vel;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Timing: 200 ticks/s * 60 s / 4 steps per beat = 3000 ticks per minute
  localparam int unsigned TICK_W         = 12;
  localparam logic [11:0] TEMPO_DIVIDEND = 12'd3000;
  localparam logic [11:0] ELAPSED_MAX    = 12'hFFF;
  localparam logic [11:0] INTERVAL_RST   = 12'd25;

  // MIDI note-on status, upper nibble (active sensing 0xFE never matches)
  localparam logic [3:0] MIDI_NOTE_ON = 4'h9;

  // Random step generator
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // One step entry: note in the upper byte, velocity in the lower
  localparam int unsigned STEP_ENTRY_W = 16;

endpackage

// ----- rtl/mss_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module mss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mss_tempo_div.sv -----
// Step interval divider: 3000 / tempo, one quotient bit per cycle
module mss_tempo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [8:0]                  tempo_i,
  output logic                        busy_o,
  output logic [mss_pkg::TICK_W-1:0]  interval_o
);
  import mss_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'(TICK_W - 1);

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [11:0] interval_q;
  logic [8:0]  div_q, rem_q, rem_d;
  logic [11:0] num_q, num_d, quo_q, quo_d;
  logic [9:0]  rem_sh, rem_sub;
  logic        fits;

  // Restoring division step
  assign rem_sh  = {rem_q, num_q[11]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign rem_d   = fits ? rem_sub[8:0] : rem_sh[8:0];
  assign quo_d   = {quo_q[10:0], fits};
  assign num_d   = {num_q[10:0], 1'b0};

  // Control and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      interval_q <= INTERVAL_RST;
    end else if (start_i) begin
      if (tempo_i == '0) begin
        interval_q <= ELAPSED_MAX;
      end else begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == LAST_STEP) begin
        busy_q     <= 1'b0;
        interval_q <= quo_d;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= tempo_i;
      rem_q <= '0;
      num_q <= TEMPO_DIVIDEND;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign interval_o = interval_q;

endmodule

// ----- rtl/mss_front.sv -----
// Front end: accepts beats, counts ticks and parses note-on messages
module mss_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mss_pkg::in_beat_t          in_beat_i,
  input  logic                       hold_i,
  input  logic                       play_stop_i,
  input  logic [3:0]                 midi_channel_i,
  input  logic [mss_pkg::TICK_W-1:0] interval_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output mss_pkg::cmd_t              cmd_o
);
  import mss_pkg::*;

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_KEY,
    PH_VEL
  } phase_e;

  phase_e      phase_q;
  logic [11:0] elapsed_q, elapsed_inc;
  logic [7:0]  pending_key_q;
  logic        accept, is_tick, tick_fire, is_status, store_hit;

  assign in_ready_o = cmd_ready_i && !hold_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = in_beat_i.opcode == OP_TICK;

  // Saturating tick counter and step trigger
  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 12'd1 : elapsed_q;
  assign tick_fire   = !play_stop_i && (elapsed_inc >= interval_i);

  // Note-on capture
  assign is_status = in_beat_i.midi_byte == {MIDI_NOTE_ON, midi_channel_i};
  assign store_hit = (phase_q == PH_VEL) && (in_beat_i.midi_byte != 8'd0);

  assign cmd_valid_o = accept && (is_tick ? tick_fire : store_hit);
  assign cmd_o.kind  = is_tick ? CMD_FIRE : CMD_STORE;
  assign cmd_o.key   = pending_key_q;
  assign cmd_o.vel   = in_beat_i.midi_byte;

  // Parser state, tick counter and held key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_STATUS;
      elapsed_q     <= '0;
      pending_key_q <= '0;
    end else if (accept) begin
      if (is_tick) begin
        elapsed_q <= tick_fire ? '0 : elapsed_inc;
      end else begin
        unique case (phase_q)
          PH_STATUS: begin
            if (is_status) begin
              phase_q <= PH_KEY;
            end
          end
          PH_KEY: begin
            pending_key_q <= in_beat_i.midi_byte;
            phase_q       <= PH_VEL;
          end
          PH_VEL: begin
            phase_q <= PH_STATUS;
          end
          default: begin
            phase_q <= PH_STATUS;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/mss_cmd_queue.sv -----
// Short command FIFO between the front end and the back end
module mss_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mss_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mss_pkg::cmd_t pop_data_o
);
  import mss_pkg::*;

  cmd_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   push, pop;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  assign push_ready_o = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
        2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/mss_back.sv -----
// Back end: plays steps, stores captured notes and drives result beats
`include "midi_step_sequencer_assert.svh"

module mss_back #(
  parameter int unsigned STEP_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  mss_pkg::cmd_t      cmd_i,
  input  logic [2:0]         play_mode_i,
  input  logic [6:0]         transpose_i,
  input  logic [3:0]         midi_channel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mss_pkg::out_beat_t out_beat_o
);
  import mss_pkg::*;

  localparam int unsigned PW    = $clog2(STEP_COUNT);
  localparam int unsigned SUM_W = PW + 2;

  logic [PW-1:0]           pos_q, pos_d, pos_next, rand_pos;
  logic [7:0]              held_q, held_d;
  logic [15:0]             lfsr_q, lfsr_d, lfsr_adv;
  logic                    off_done_q, off_done_d;
  logic [STEP_COUNT-1:0]   valid_q;
  logic                    byp_valid_q, byp_valid_d;
  logic [STEP_ENTRY_W-1:0] byp_data_q, ram_rdata, step_ent, wdata;
  logic [7:0]              step_note, step_vel, on_note;
  logic                    we, emit, emit_on, can_emit, rand_mode, advance;
  logic                    out_valid_q;
  out_beat_t               out_q, out_d;
  logic [PW-1:0]           nib_res [4][16];
  logic [SUM_W-1:0]        res_sum, red1;

  // Step store, read at the next position so the registered data is the current step
  assign wdata = {cmd_i.key, cmd_i.vel};

  mss_ram #(
    .WIDTH (STEP_ENTRY_W),
    .DEPTH (STEP_COUNT)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .raddr_i (pos_d),
    .rdata_o (ram_rdata)
  );

  // Current step, with bypass of a store made last cycle
  assign step_ent  = byp_valid_q ? byp_data_q : ram_rdata;
  assign step_note = valid_q[pos_q] ? step_ent[15:8] : 8'd0;
  assign step_vel  = step_ent[7:0];
  assign on_note   = step_note + {transpose_i[6], transpose_i};

  // Random position: Galois LFSR step, then residue by nibble tables
  assign lfsr_adv = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);

  for (genvar k = 0; k < 4; k++) begin : g_nib
    for (genvar n = 0; n < 16; n++) begin : g_val
      localparam int unsigned RES = (n << (4 * k)) % STEP_COUNT;
      assign nib_res[k][n] = PW'(RES);
    end
  end

  assign res_sum = SUM_W'(nib_res[0][lfsr_adv[3:0]])  + SUM_W'(nib_res[1][lfsr_adv[7:4]])
                 + SUM_W'(nib_res[2][lfsr_adv[11:8]]) + SUM_W'(nib_res[3][lfsr_adv[15:12]]);
  assign red1 = (res_sum >= SUM_W'(2 * STEP_COUNT)) ? res_sum - SUM_W'(2 * STEP_COUNT)
                                                    : res_sum;
  assign rand_pos = (red1 >= SUM_W'(STEP_COUNT)) ? PW'(red1 - SUM_W'(STEP_COUNT))
                                                 : PW'(red1);

  // Next position by play mode
  assign rand_mode = (play_mode_i != PLAY_FORWARD) && (play_mode_i != PLAY_BACKWARD);

  always_comb begin
    if (play_mode_i == PLAY_BACKWARD) begin
      pos_next = (pos_q == '0) ? PW'(STEP_COUNT - 1) : pos_q - PW'(1);
    end else if (play_mode_i == PLAY_FORWARD) begin
      pos_next = (pos_q == PW'(STEP_COUNT - 1)) ? '0 : pos_q + PW'(1);
    end else begin
      pos_next = rand_pos;
    end
  end

  assign can_emit = !out_valid_q || out_ready_i;

  // Command execution; a fire with both a held note and a step note takes two beats
  always_comb begin
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    emit_on     = 1'b0;
    we          = 1'b0;
    advance     = 1'b0;
    held_d      = held_q;
    off_done_d  = off_done_q;
    out_d.event_kind    = EV_STEP_STORED;
    out_d.event_channel = midi_channel_i;
    out_d.note_number   = cmd_i.key;
    out_d.velocity      = cmd_i.vel;
    out_d.step_index    = STEP_IDX_W'(pos_q);
    out_d.last_of_run   = 1'b1;
    if (cmd_valid_i) begin
      unique case (cmd_i.kind)
        CMD_STORE: begin
          if (can_emit) begin
            emit        = 1'b1;
            we          = 1'b1;
            cmd_ready_o = 1'b1;
          end
        end
        CMD_FIRE: begin
          if ((held_q != 8'd0) && !off_done_q) begin
            out_d.event_kind  = EV_NOTE_OFF;
            out_d.note_number = held_q;
            out_d.velocity    = 8'd0;
            out_d.last_of_run = step_note == 8'd0;
            if (can_emit) begin
              emit = 1'b1;
              if (step_note == 8'd0) begin
                advance     = 1'b1;
                cmd_ready_o = 1'b1;
              end else begin
                off_done_d = 1'b1;
              end
            end
          end else if (step_note != 8'd0) begin
            out_d.event_kind  = EV_NOTE_ON;
            out_d.note_number = on_note;
            out_d.velocity    = step_vel;
            if (can_emit) begin
              emit        = 1'b1;
              emit_on     = 1'b1;
              held_d      = on_note;
              advance     = 1'b1;
              cmd_ready_o = 1'b1;
              off_done_d  = 1'b0;
            end
          end else begin
            advance     = 1'b1;
            cmd_ready_o = 1'b1;
            off_done_d  = 1'b0;
          end
        end
        default: begin
          cmd_ready_o = 1'b0;
        end
      endcase
    end
  end

  assign pos_d       = advance ? pos_next : pos_q;
  assign lfsr_d      = (advance && rand_mode) ? lfsr_adv : lfsr_q;
  assign byp_valid_d = we && (pos_d == pos_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_q      <= '0;
      lfsr_q      <= LFSR_SEED;
      off_done_q  <= 1'b0;
      valid_q     <= '0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      held_q      <= held_d;
      lfsr_q      <= lfsr_d;
      off_done_q  <= off_done_d;
      byp_valid_q <= byp_valid_d;
      if (we) begin
        valid_q[pos_q] <= 1'b1;
      end
      if (can_emit) begin
        out_valid_q <= emit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
    if (can_emit && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `MSS_ASSERT(a_off_done_on_fire, !off_done_q || (cmd_valid_i && (cmd_i.kind == CMD_FIRE)), "second beat of a fire without a fire command")
  `MSS_ASSERT(a_pos_in_range, pos_q <= PW'(STEP_COUNT - 1), "step position out of range")
  `MSS_ASSERT_NEXT(a_held_follows_on, emit_on, held_q == $past(on_note), "held note not updated on note on")
  `MSS_ASSERT_NEXT(a_store_reads_back, we, step_note == $past(cmd_i.key), "stored note not seen on the current step")

endmodule

// ----- rtl/midi_step_sequencer.sv -----
// Top level of the eight-step MIDI step sequencer
//
// Channel  Direction  Handshake              Beat
// in       input      in_valid/in_ready      opcode, midi_byte
// out      output     out_valid/out_ready    event fields, last_of_run
// cfg      input      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One input beat a cycle unless the queue is full or the divider busy; registered output.
// A fire with both a held note and a step note occupies the back end for a
// note off, then a note on; a two-entry command queue absorbs that.
// A tempo write runs the divider; input and cfg are held off meanwhile.
// Reset clears the control state at once, not the step RAM; steps use per-step valid bits.
module midi_step_sequencer #(
  parameter int unsigned STEP_COUNT = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mss_pkg::in_beat_t                   in_beat_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mss_pkg::out_beat_t                  out_beat_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [mss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mss_pkg::*;

  logic        cfg_write, div_start, div_busy;
  logic [2:0]  play_mode_q;
  logic [6:0]  transpose_q;
  logic [3:0]  midi_channel_q;
  logic [11:0] interval;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_cmd, qb_cmd;

  assign cfg_ready_o = !div_busy;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign div_start   = cfg_write && (cfg_index_i == CFG_TEMPO);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_mode_q    <= PLAY_MODE_RST;
      transpose_q    <= '0;
      midi_channel_q <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_TEMPO:        play_mode_q    <= play_mode_q;
        CFG_PLAY_MODE:    play_mode_q    <= cfg_data_i[2:0];
        CFG_TRANSPOSE:    transpose_q    <= cfg_data_i[6:0];
        CFG_MIDI_CHANNEL: midi_channel_q <= cfg_data_i[3:0];
        default:          play_mode_q    <= play_mode_q;
      endcase
    end
  end

  mss_tempo_div u_tempo_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .tempo_i    (cfg_data_i),
    .busy_o     (div_busy),
    .interval_o (interval)
  );

  mss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_beat_i      (in_beat_i),
    .hold_i         (div_busy),
    .play_stop_i    (play_mode_q[0]),
    .midi_channel_i (midi_channel_q),
    .interval_i     (interval),
    .cmd_valid_o    (fq_valid),
    .cmd_ready_i    (fq_ready),
    .cmd_o          (fq_cmd)
  );

  mss_cmd_queue u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  mss_back #(
    .STEP_COUNT (STEP_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (qb_valid),
    .cmd_ready_o    (qb_ready),
    .cmd_i          (qb_cmd),
    .play_mode_i    (play_mode_q),
    .transpose_i    (transpose_q),
    .midi_channel_i (midi_channel_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_beat_o     (out_beat_o)
  );

endmodule

// ----- tb/midi_step_sequencer_test.sv -----
// Self-checking testbench for the eight-step MIDI step sequencer
module midi_step_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned STEPS        = 8;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned IDLE_PCT     = 14;
  localparam logic [7:0]  ACTIVE_SENSE = 8'hFE;

  // MIDI parser positions within a note-on message
  typedef enum logic [1:0] {
    WAIT_STATUS,
    WAIT_KEY,
    WAIT_VELOCITY
  } parse_e;

  // Predicts the sequencer events and holds them until they leave the block
  class step_scoreboard;
    logic [7:0]  notes [STEPS];
    logic [7:0]  vels [STEPS];
    logic [2:0]  pos;
    logic [7:0]  held;
    logic [11:0] elapsed;
    logic [11:0] interval;
    parse_e      parse;
    logic [7:0]  key;
    logic [15:0] lfsr;
    logic [2:0]  mode;
    logic [6:0]  transp;
    logic [3:0]  chan;
    out_beat_t   expected_q[$];
    int unsigned errors;

    function new();
      foreach (notes[i]) begin
        notes[i] = '0;
        vels[i]  = '0;
      end
      pos      = '0;
      held     = '0;
      elapsed  = '0;
      interval = INTERVAL_RST;
      parse    = WAIT_STATUS;
      key      = '0;
      lfsr     = LFSR_SEED;
      mode     = PLAY_MODE_RST;
      transp   = '0;
      chan     = '0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TEMPO: begin
          interval = (data == '0) ? ELAPSED_MAX : TEMPO_DIVIDEND / data;
        end
        CFG_PLAY_MODE:    mode   = data[2:0];
        CFG_TRANSPOSE:    transp = data[6:0];
        CFG_MIDI_CHANNEL: chan   = data[3:0];
        default: ;
      endcase
    endfunction

    function void push_event(ev_kind_e kind, logic [7:0] note, logic [7:0] vel, logic last);
      out_beat_t ev;
      ev.event_kind    = kind;
      ev.event_channel = chan;
      ev.note_number   = note;
      ev.velocity      = vel;
      ev.step_index    = pos;
      ev.last_of_run   = last;
      expected_q.push_back(ev);
    endfunction

    // Work out the events caused by one accepted input beat
    function void note_input(in_beat_t b);
      logic [7:0] note;
      if (b.opcode == OP_TICK) begin
        if (elapsed != ELAPSED_MAX) elapsed++;
        if (!mode[0] && elapsed >= interval) begin
          if (held != '0) push_event(EV_NOTE_OFF, held, 8'h00, notes[pos] == '0);
          if (notes[pos] != '0) begin
            note = notes[pos] + {transp[6], transp};
            push_event(EV_NOTE_ON, note, vels[pos], 1'b1);
            held = note;
          end
          // move to the next step
          case (mode)
            PLAY_BACKWARD: pos = pos - 3'd1;
            PLAY_FORWARD:  pos = pos + 3'd1;
            default: begin
              lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
              pos  = lfsr[2:0];
            end
          endcase
          elapsed = '0;
        end
      end else begin
        case (parse)
          WAIT_STATUS: if (b.midi_byte == {MIDI_NOTE_ON, chan}) parse = WAIT_KEY;
          WAIT_KEY: begin
            key   = b.midi_byte;
            parse = WAIT_VELOCITY;
          end
          default: begin
            parse = WAIT_STATUS;
            if (b.midi_byte != '0) begin
              notes[pos] = key;
              vels[pos]  = b.midi_byte;
              push_event(EV_STEP_STORED, key, b.midi_byte, 1'b1);
            end
          end
        endcase
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    // Compare one output beat with the oldest predicted event
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
      compare_field("event_channel", 8'(want.event_channel), 8'(got.event_channel));
      compare_field("note_number", want.note_number, got.note_number);
      compare_field("velocity", want.velocity, got.velocity);
      compare_field("step_index", 8'(want.step_index), 8'(got.step_index));
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready_o;
  in_beat_t              in_beat   = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index = CFG_TEMPO;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  no_idle   = 1'b0;
  step_scoreboard        sb;

  midi_step_sequencer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver side: random back-pressure
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every accepted output beat
  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) sb.check_result(out_beat);
  end

  // Send one input beat, with an occasional idle cycle before it
  task automatic send_beat(input op_e op, input logic [7:0] data);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{opcode: op, midi_byte: data};
    do @(posedge clk); while (!in_ready_o);
    sb.note_input(in_beat);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_beat(OP_MIDI_BYTE, data);
  endtask

  // Hold input off until every predicted event has left, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [8:0] tempo, input logic [2:0] mode,
                           input logic [6:0] transp, input logic [3:0] chan);
    wait_quiet();
    write_reg(CFG_TEMPO, tempo);
    write_reg(CFG_PLAY_MODE, 9'(mode));
    write_reg(CFG_TRANSPOSE, 9'(transp));
    write_reg(CFG_MIDI_CHANNEL, 9'(chan));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned count;
    int unsigned r;
    logic [8:0]  tempo;
    logic [2:0]  mode;
    logic [6:0]  transp;

    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Stopped after reset: parser corner cases on channel 0
    send_byte(ACTIVE_SENSE);
    send_byte(8'h80);
    send_byte(8'h91);
    send_byte(8'h90);
    send_byte(8'h40);
    send_ticks(1);
    send_byte(8'h7F);
    send_byte(8'h90);
    send_byte(8'h45);
    send_byte(8'h00);

    // Fastest tempo, forward, lowest transpose: transposed note zero first
    configure(9'd511, PLAY_FORWARD, 7'h40, 4'd15);
    send_ticks(5);
    send_byte(8'h9F);
    send_byte(ACTIVE_SENSE);
    send_byte(8'h01);
    send_ticks(15);

    // Count keeps running while stopped, so the first tick after resuming fires
    configure(9'd300, PLAY_MODE_RST, 7'h3F, 4'd0);
    send_byte(8'h90);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_ticks(20);
    configure(9'd300, PLAY_BACKWARD, 7'h3F, 4'd0);
    send_ticks(2);

    // Tempo zero gives the longest interval
    configure(9'd0, 3'd6, 7'h00, 4'd5);
    send_byte(8'h95);
    send_byte(8'h3C);
    send_byte(8'h64);
    send_ticks(8);

    // Random phases: mostly note-on messages and ticks, some noise
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      case ($urandom_range(5))
        0:       tempo = 9'd300;
        1:       tempo = 9'd511;
        default: tempo = 9'($urandom_range(150, 511));
      endcase
      mode = 3'($urandom_range(7));
      if ($urandom_range(3) != 0) mode[0] = 1'b0;
      transp = 7'($urandom_range(127));
      if ($urandom_range(3) == 0) transp = $urandom_range(1) ? 7'h3F : 7'h40;
      configure(tempo, mode, transp, 4'($urandom_range(15)));
      no_idle = (phase_no == 3);
      count = 0;
      while (count < 40) begin
        r = $urandom_range(99);
        if (r < 45) begin
          send_ticks(1);
          count++;
        end else if (r < 85) begin
          if ($urandom_range(3) == 0) send_byte(ACTIVE_SENSE);
          send_byte({MIDI_NOTE_ON, sb.chan});
          send_byte(8'($urandom_range(255)));
          if ($urandom_range(7) == 0) send_ticks(1);
          send_byte($urandom_range(9) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
          count += 3;
        end else if (r < 93) begin
          send_byte(8'($urandom_range(255)));
          count++;
        end else begin
          // message cut short
          send_byte({MIDI_NOTE_ON, sb.chan});
          send_byte(8'($urandom_range(255)));
          count += 2;
        end
      end
      no_idle = 1'b0;
    end

    wait_quiet();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- midi_step_sequencer.f -----
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_ram.sv
rtl/mss_tempo_div.sv
rtl/mss_front.sv
rtl/mss_cmd_queue.sv
rtl/mss_back.sv
rtl/midi_step_sequencer.sv
tb/midi_step_sequencer_test.sv
